// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define WCG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition that must never hold at a clock edge.
`define WCG_ASSERT_NEVER(lbl, cond) \
  `WCG_ASSERT(lbl, !(cond))

`endif

// ===== sv/wcg_pkg.sv =====
`timescale 1ns / 1ps
package wcg_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned ITEM_W    = 10;
  localparam int unsigned CONCEPT_W = 6;
  localparam int unsigned MASK_W    = 64;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned VALUE_W   = 38;
  // selection bits are kept as rows of 64, one row per memory word
  localparam int unsigned ROW_BITS  = 64;
  localparam int unsigned ROW_SEL_W = 6;
  // wide enough for any item index the parameter range allows
  localparam int unsigned EXT_W     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MASK   = 3'd0,
    OP_LOAD_WEIGHT = 3'd1,
    OP_GAIN        = 3'd2,
    OP_ADD         = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_EVAL        = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    K_LOAD_MASK,
    K_LOAD_WEIGHT,
    K_GAIN,
    K_GAIN_NULL,
    K_ADD,
    K_CLEAR,
    K_EVAL
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SUM,
    ST_TAIL,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [ITEM_W-1:0]    item;
    logic [CONCEPT_W-1:0] concept;
    logic [MASK_W-1:0]    mask;
    logic [WEIGHT_W-1:0]  weight;
    logic                 check;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

endpackage

// ===== sv/weighted_coverage_gain_top.sv =====
// Weighted set-cover scorer. Commands enter through a two-deep queue and are
// run one at a time: a mask or weight load is written from idle, an add
// reads its selection row and mask in a fetch state, and a gain query that is
// not a membership hit, or an evaluate, sums through the single 38-bit adder
// that walks the weight memory one concept per cycle. A clear, and the pass
// that follows reset, wipe the selection memory one 64-item row per cycle;
// full stays high during each wipe. Each result sits in an output register
// until popped, so the next command may start meanwhile; a gain or evaluate
// stalls at its end only while the previous result has not been taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module weighted_coverage_gain_top import wcg_pkg::*; #(
  parameter int unsigned NUM_ITEMS    = 1024,
  parameter int unsigned NUM_CONCEPTS = 64,
  parameter int unsigned WEIGHT_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [ITEM_W-1:0]    item_index_i,
  input  logic [CONCEPT_W-1:0] concept_index_i,
  input  logic [MASK_W-1:0]    cover_mask_i,
  input  logic [WEIGHT_W-1:0]  weight_i,
  input  logic                 check_membership_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [VALUE_W-1:0]   value_o,
  output logic                 already_selected_o
);

  back_stat_t stat;
  logic       cmd_vld;
  cmd_t       cmd;
  logic       out_vld;

  wcg_front #(
    .NUM_ITEMS    (NUM_ITEMS),
    .NUM_CONCEPTS (NUM_CONCEPTS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_o             (full),
    .operation_i        (operation_i),
    .item_index_i       (item_index_i),
    .concept_index_i    (concept_index_i),
    .cover_mask_i       (cover_mask_i),
    .weight_i           (weight_i),
    .check_membership_i (check_membership_i),
    .stat_i             (stat),
    .cmd_vld_o          (cmd_vld),
    .cmd_o              (cmd)
  );

  wcg_back #(
    .NUM_ITEMS    (NUM_ITEMS),
    .NUM_CONCEPTS (NUM_CONCEPTS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_vld_i          (cmd_vld),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .pop_i              (pop),
    .out_vld_o          (out_vld),
    .value_o            (value_o),
    .already_selected_o (already_selected_o)
  );

  assign empty = !out_vld;

  // the back end only takes a beat from the queue when one is waiting
  `WCG_ASSERT(a_pop_has_cmd, stat.pop |-> cmd_vld)
  // no command runs while the selection rows are being wiped
  `WCG_ASSERT_NEVER(a_no_pop_in_clear, stat.busy && stat.pop)
  // a membership hit always reports a zero gain
  `WCG_ASSERT(a_hit_is_zero, (!empty && already_selected_o) |-> (value_o == '0))

endmodule

// ===== sv/wcg_front.sv =====
`timescale 1ns / 1ps
module wcg_front import wcg_pkg::*; #(
  parameter int unsigned NUM_ITEMS    = 1024,
  parameter int unsigned NUM_CONCEPTS = 64,
  parameter int unsigned WEIGHT_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [ITEM_W-1:0]    item_index_i,
  input  logic [CONCEPT_W-1:0] concept_index_i,
  input  logic [MASK_W-1:0]    cover_mask_i,
  input  logic [WEIGHT_W-1:0]  weight_i,
  input  logic                 check_membership_i,
  input  back_stat_t           stat_i,
  output logic                 cmd_vld_o,
  output cmd_t                 cmd_o
);

  localparam logic [MASK_W-1:0]   MASK_KEEP   = {MASK_W{1'b1}} >> (MASK_W - NUM_CONCEPTS);
  localparam logic [WEIGHT_W-1:0] WEIGHT_KEEP = {WEIGHT_W{1'b1}} >> (WEIGHT_W - WEIGHT_BITS);

  cmd_t       q_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       item_ok, concept_ok, keep, enq;
  cmd_t       cmd;

  always_comb begin
    item_ok     = 32'(item_index_i) < NUM_ITEMS;
    concept_ok  = 32'(concept_index_i) < NUM_CONCEPTS;
    keep        = 1'b1;
    cmd.item    = item_index_i;
    cmd.concept = concept_index_i;
    cmd.mask    = cover_mask_i & MASK_KEEP;
    cmd.weight  = weight_i & WEIGHT_KEEP;
    cmd.check   = check_membership_i;
    cmd.kind    = K_EVAL;
    // out-of-range loads and adds are dropped here; unused codes likewise
    unique case (op_e'(operation_i))
      OP_LOAD_MASK: begin
        cmd.kind = K_LOAD_MASK;
        keep     = item_ok;
      end
      OP_LOAD_WEIGHT: begin
        cmd.kind = K_LOAD_WEIGHT;
        keep     = concept_ok;
      end
      OP_GAIN: begin
        cmd.kind = item_ok ? K_GAIN : K_GAIN_NULL;
      end
      OP_ADD: begin
        cmd.kind = K_ADD;
        keep     = item_ok;
      end
      OP_CLEAR: begin
        cmd.kind = K_CLEAR;
      end
      OP_EVAL: begin
        cmd.kind = K_EVAL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o    = (cnt_q == 2'd2) || stat_i.busy;
  assign enq       = push_i && !full_o && keep;
  assign cmd_vld_o = cnt_q != 2'd0;
  assign cmd_o     = q_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (enq) begin
      wp_d = !wp_q;
    end
    if (stat_i.pop) begin
      rp_d = !rp_q;
    end
    unique case ({enq, stat_i.pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_q[wp_q] <= cmd;
    end
  end

endmodule

// ===== sv/wcg_back.sv =====
`timescale 1ns / 1ps
module wcg_back import wcg_pkg::*; #(
  parameter int unsigned NUM_ITEMS    = 1024,
  parameter int unsigned NUM_CONCEPTS = 64,
  parameter int unsigned WEIGHT_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_vld_i,
  input  cmd_t               cmd_i,
  output back_stat_t         stat_o,
  input  logic               pop_i,
  output logic               out_vld_o,
  output logic [VALUE_W-1:0] value_o,
  output logic               already_selected_o
);

  localparam int unsigned IDX_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int unsigned ROWS  = (NUM_ITEMS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CI_W  = (NUM_CONCEPTS > 1) ? $clog2(NUM_CONCEPTS) : 1;

  logic [NUM_CONCEPTS-1:0] cover_mem [NUM_ITEMS];
  logic [WEIGHT_BITS-1:0]  wt_mem    [NUM_CONCEPTS];
  logic [ROW_BITS-1:0]     sel_mem   [ROWS];

  state_e                  state_q, state_d;
  cmd_t                    cur_q, cur_d;
  logic [NUM_CONCEPTS-1:0] cov_q, cov_d;
  logic [NUM_CONCEPTS-1:0] sum_q, sum_d;
  logic [CI_W-1:0]         cnt_q, cnt_d;
  logic                    take_q, take_d;
  logic                    pend_q, pend_d;
  logic [VALUE_W-1:0]      acc_q, acc_d;
  logic                    flag_q, flag_d;
  logic [ROW_W-1:0]        clr_q, clr_d;
  logic                    out_vld_q, out_vld_d;
  logic [VALUE_W-1:0]      out_val_q, out_val_d;
  logic                    out_flag_q, out_flag_d;

  logic [NUM_CONCEPTS-1:0] cover_rd_q;
  logic [ROW_BITS-1:0]     sel_rd_q;
  logic [WEIGHT_BITS-1:0]  wt_rd_q;

  logic                    cover_we, wt_we, sel_we, pop;
  logic [IDX_W-1:0]        cover_wa;
  logic [CI_W-1:0]         wt_wa;
  logic [ROW_W-1:0]        sel_wa;
  logic [ROW_BITS-1:0]     sel_wd;
  logic [EXT_W-1:0]        head_ext, cur_ext;
  logic [EXT_W-ROW_SEL_W-1:0] head_row, cur_row;
  logic                    sel_bit;

  assign head_ext = EXT_W'(cmd_i.item);
  assign cur_ext  = EXT_W'(cur_q.item);
  assign head_row = head_ext[EXT_W-1:ROW_SEL_W];
  assign cur_row  = cur_ext[EXT_W-1:ROW_SEL_W];
  assign sel_bit  = sel_rd_q[cur_ext[ROW_SEL_W-1:0]];

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    cov_d      = cov_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    take_d     = take_q;
    pend_d     = 1'b0;
    acc_d      = acc_q;
    flag_d     = flag_q;
    clr_d      = clr_q;
    out_vld_d  = out_vld_q;
    out_val_d  = out_val_q;
    out_flag_d = out_flag_q;
    cover_we   = 1'b0;
    cover_wa   = head_ext[IDX_W-1:0];
    wt_we      = 1'b0;
    wt_wa      = cmd_i.concept[CI_W-1:0];
    sel_we     = 1'b0;
    sel_wa     = cur_row[ROW_W-1:0];
    sel_wd     = sel_rd_q | (ROW_BITS'(1) << cur_ext[ROW_SEL_W-1:0]);
    pop        = 1'b0;

    if (out_vld_q && pop_i) begin
      out_vld_d = 1'b0;
    end
    // weight data is registered, so it arrives in the cycle after its address
    if (pend_q && take_q) begin
      acc_d = acc_q + VALUE_W'(wt_rd_q);
    end

    unique case (state_q)
      ST_CLEAR: begin
        sel_we = 1'b1;
        sel_wa = clr_q;
        sel_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ROW_W'(ROWS - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_vld_i) begin
          pop   = 1'b1;
          cur_d = cmd_i;
          unique case (cmd_i.kind)
            K_LOAD_MASK: begin
              cover_we = 1'b1;
            end
            K_LOAD_WEIGHT: begin
              wt_we = 1'b1;
            end
            K_GAIN, K_ADD: begin
              state_d = ST_FETCH;
            end
            K_GAIN_NULL: begin
              acc_d   = '0;
              flag_d  = 1'b0;
              state_d = ST_DONE;
            end
            K_CLEAR: begin
              cov_d   = '0;
              state_d = ST_CLEAR;
            end
            K_EVAL: begin
              sum_d   = cov_q;
              acc_d   = '0;
              flag_d  = 1'b0;
              cnt_d   = '0;
              state_d = ST_SUM;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (cur_q.kind == K_ADD) begin
          if (!sel_bit) begin
            cov_d  = cov_q | cover_rd_q;
            sel_we = 1'b1;
          end
          state_d = ST_IDLE;
        end else if (cur_q.check && sel_bit) begin
          acc_d   = '0;
          flag_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          sum_d   = cover_rd_q & ~cov_q;
          acc_d   = '0;
          flag_d  = 1'b0;
          cnt_d   = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        pend_d = 1'b1;
        take_d = sum_q[0];
        sum_d  = sum_q >> 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CI_W'(NUM_CONCEPTS - 1)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || pop_i) begin
          out_vld_d  = 1'b1;
          out_val_d  = acc_q;
          out_flag_d = flag_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cov_q     <= '0;
      pend_q    <= 1'b0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cov_q     <= cov_d;
      pend_q    <= pend_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    sum_q      <= sum_d;
    cnt_q      <= cnt_d;
    take_q     <= take_d;
    acc_q      <= acc_d;
    flag_q     <= flag_d;
    out_val_q  <= out_val_d;
    out_flag_q <= out_flag_d;
  end

  always_ff @(posedge clk_i) begin
    if (cover_we) begin
      cover_mem[cover_wa] <= cmd_i.mask[NUM_CONCEPTS-1:0];
    end
    cover_rd_q <= cover_mem[head_ext[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_wa] <= cmd_i.weight[WEIGHT_BITS-1:0];
    end
    wt_rd_q <= wt_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (sel_we) begin
      sel_mem[sel_wa] <= sel_wd;
    end
    sel_rd_q <= sel_mem[head_row[ROW_W-1:0]];
  end

  assign stat_o.pop         = pop;
  assign stat_o.busy        = state_q == ST_CLEAR;
  assign out_vld_o          = out_vld_q;
  assign value_o            = out_val_q;
  assign already_selected_o = out_flag_q;

endmodule

// ===== tb/sv/weighted_coverage_gain_top_tb.sv =====
`timescale 1ns / 1ps
module weighted_coverage_gain_top_tb;
  import wcg_pkg::*;

  localparam int unsigned NUM_ITEMS     = 1024;
  localparam int unsigned NUM_CONCEPTS  = 64;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned HOLD_OFF      = 600;

  // codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               flag;
  } score_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [OP_W-1:0]      operation;
  logic [ITEM_W-1:0]    item_index;
  logic [CONCEPT_W-1:0] concept_index;
  logic [MASK_W-1:0]    cover_mask;
  logic [WEIGHT_W-1:0]  weight;
  logic                 check_membership;
  logic                 empty;
  logic                 pop;
  logic [VALUE_W-1:0]   value;
  logic                 already_selected;

  // scoreboard copy of the block state
  logic [MASK_W-1:0]   mask_mem [NUM_ITEMS];
  logic [WEIGHT_W-1:0] weight_mem [NUM_CONCEPTS];
  logic [MASK_W-1:0]   covered_now;
  bit                  picked [NUM_ITEMS];
  bit                  mask_loaded [NUM_ITEMS];
  int unsigned         loaded_items[$];
  int unsigned         last_added;
  score_t              expected_scores[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_cycles    = 0;

  always #5 clk_i = ~clk_i;

  weighted_coverage_gain_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .operation_i        (operation),
    .item_index_i       (item_index),
    .concept_index_i    (concept_index),
    .cover_mask_i       (cover_mask),
    .weight_i           (weight),
    .check_membership_i (check_membership),
    .empty              (empty),
    .pop                (pop),
    .value_o            (value),
    .already_selected_o (already_selected)
  );

  function automatic logic [VALUE_W-1:0] sum_weights(input logic [MASK_W-1:0] m);
    logic [VALUE_W-1:0] acc;
    acc = '0;
    for (int c = 0; c < NUM_CONCEPTS; c++) begin
      if (m[c]) acc += VALUE_W'(weight_mem[c]);
    end
    return acc;
  endfunction

  function automatic void predict_command(
    input logic [OP_W-1:0]      op,
    input logic [ITEM_W-1:0]    item,
    input logic [CONCEPT_W-1:0] concept,
    input logic [MASK_W-1:0]    mask,
    input logic [WEIGHT_W-1:0]  w,
    input logic                 check
  );
    score_t s;
    s.value = '0;
    s.flag  = 1'b0;
    case (op)
      OP_LOAD_MASK: begin
        mask_mem[item] = mask;
        if (!mask_loaded[item]) begin
          mask_loaded[item] = 1'b1;
          loaded_items.push_back(item);
        end
      end
      OP_LOAD_WEIGHT: weight_mem[concept] = w;
      OP_GAIN: begin
        if (check && picked[item]) s.flag = 1'b1;
        else s.value = sum_weights(mask_mem[item] & ~covered_now);
        expected_scores.push_back(s);
      end
      OP_ADD: begin
        if (!picked[item]) begin
          covered_now |= mask_mem[item];
          picked[item] = 1'b1;
        end
      end
      OP_CLEAR: begin
        covered_now = '0;
        foreach (picked[i]) picked[i] = 1'b0;
      end
      OP_EVAL: begin
        s.value = sum_weights(covered_now);
        expected_scores.push_back(s);
      end
      default: ;
    endcase
  endfunction

  // starts and ends on a falling edge; push stays high into the next call
  task automatic send_beat(
    input logic [OP_W-1:0]      op,
    input logic [ITEM_W-1:0]    item,
    input logic [CONCEPT_W-1:0] concept,
    input logic [MASK_W-1:0]    mask,
    input logic [WEIGHT_W-1:0]  w,
    input logic                 check
  );
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push             <= 1'b1;
    operation        <= op;
    item_index       <= item;
    concept_index    <= concept;
    cover_mask       <= mask;
    weight           <= w;
    check_membership <= check;
    do @(posedge clk_i); while (full);
    predict_command(op, item, concept, mask, w, check);
    @(negedge clk_i);
  endtask

  function automatic logic [MASK_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [MASK_W-1:0] rand_cover_mask();
    case ($urandom_range(3))
      0: return rand_word();
      1: return rand_word() & rand_word() & rand_word();
      2: return MASK_W'(1) << $urandom_range(NUM_CONCEPTS - 1);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [ITEM_W-1:0] any_loaded_item();
    return ITEM_W'(loaded_items[$urandom_range(loaded_items.size() - 1)]);
  endfunction

  task automatic test_table_load();
    for (int c = 0; c < NUM_CONCEPTS; c++) begin
      send_beat(OP_LOAD_WEIGHT, ITEM_W'($urandom()), CONCEPT_W'(c), rand_word(), '1,
                1'($urandom()));
    end
    send_beat(OP_LOAD_MASK, 10'd0,    '0, '0, '0, 1'b0);
    send_beat(OP_LOAD_MASK, 10'd1023, '0, '1, '0, 1'b1);
    send_beat(OP_LOAD_MASK, 10'd1,    '0, 64'h1, '0, 1'b0);
    send_beat(OP_LOAD_MASK, 10'd2,    '0, 64'h8000_0000_0000_0000, '0, 1'b0);
    send_beat(OP_LOAD_MASK, 10'd3,    '0, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0);
    send_beat(OP_LOAD_MASK, 10'd4,    '0, 64'h5555_5555_5555_5555, '0, 1'b0);
  endtask

  task automatic test_directed_cases();
    send_beat(OP_GAIN,  10'd1023, '0, '0, '0, 1'b1);  // full mask, all weights at max
    send_beat(OP_GAIN,  10'd0,    '0, '0, '0, 1'b0);  // empty mask
    send_beat(OP_EVAL,  '0,       '0, '0, '0, 1'b0);
    send_beat(OP_ADD,   10'd1023, '0, '0, '0, 1'b0);
    send_beat(OP_EVAL,  '0,       '0, '0, '0, 1'b0);
    send_beat(OP_GAIN,  10'd1023, '0, '0, '0, 1'b1);  // selected, flagged
    send_beat(OP_GAIN,  10'd1023, '0, '0, '0, 1'b0);  // selected, no check
    send_beat(OP_ADD,   10'd1023, '0, '0, '0, 1'b0);  // re-add
    send_beat(OP_ADD,   10'd0,    '0, '0, '0, 1'b0);
    send_beat(OP_CLEAR, '1,       '1, '1, '1, 1'b1);
    send_beat(OP_GAIN,  10'd1023, '0, '0, '0, 1'b1);
    send_beat(OP_EVAL,  '0,       '0, '0, '0, 1'b1);
    send_beat(OP_ADD,   10'd3,    '0, '0, '0, 1'b0);
    send_beat(OP_GAIN,  10'd4,    '0, '0, '0, 1'b1);
    send_beat(OP_GAIN,  10'd1023, '0, '0, '0, 1'b0);
    send_beat(OP_LOAD_WEIGHT, '0, 6'd0,  '1, '0, 1'b0);
    send_beat(OP_LOAD_WEIGHT, '1, 6'd63, '0, '0, 1'b1);
    send_beat(OP_GAIN,  10'd1,    '0, '0, '0, 1'b0);
    send_beat(OP_GAIN,  10'd2,    '0, '0, '0, 1'b1);
    send_beat(OP_SPARE_LO, 10'd1023, '1, '1, '1, 1'b1);
    send_beat(OP_SPARE_HI, 10'd5,    '1, '1, '1, 1'b1);
    send_beat(OP_EVAL,  '0,       '0, '0, '0, 1'b0);
    send_beat(OP_ADD,   10'd4,    '0, '0, '0, 1'b0);
    send_beat(OP_EVAL,  '1,       '1, '1, '1, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned        sent;
    int unsigned        roll;
    logic [ITEM_W-1:0]  item;
    logic [WEIGHT_W-1:0] w;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      item = any_loaded_item();
      if (roll < 15) begin
        // mostly a small window so queries often hit selected items
        item = $urandom_range(99) < 60 ? ITEM_W'($urandom_range(47))
                                       : ITEM_W'($urandom_range(NUM_ITEMS - 1));
        send_beat(OP_LOAD_MASK, item, CONCEPT_W'($urandom()), rand_cover_mask(),
                  WEIGHT_W'($urandom()), 1'($urandom()));
      end else if (roll < 25) begin
        case ($urandom_range(9))
          0:       w = '0;
          1:       w = '1;
          default: w = WEIGHT_W'($urandom());
        endcase
        send_beat(OP_LOAD_WEIGHT, ITEM_W'($urandom()), CONCEPT_W'($urandom_range(63)),
                  rand_word(), w, 1'($urandom()));
      end else if (roll < 55) begin
        if ($urandom_range(99) < 30) item = ITEM_W'(last_added);
        send_beat(OP_GAIN, item, CONCEPT_W'($urandom()), rand_word(),
                  WEIGHT_W'($urandom()), 1'($urandom()));
      end else if (roll < 75) begin
        last_added = item;
        send_beat(OP_ADD, item, CONCEPT_W'($urandom()), rand_word(),
                  WEIGHT_W'($urandom()), 1'($urandom()));
      end else if (roll < 80) begin
        send_beat(OP_CLEAR, ITEM_W'($urandom()), CONCEPT_W'($urandom()), rand_word(),
                  WEIGHT_W'($urandom()), 1'($urandom()));
      end else if (roll < 97) begin
        send_beat(OP_EVAL, ITEM_W'($urandom()), CONCEPT_W'($urandom()), rand_word(),
                  WEIGHT_W'($urandom()), 1'($urandom()));
      end else begin
        // ignored codes, not counted
        send_beat($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI, ITEM_W'($urandom()),
                  CONCEPT_W'($urandom()), rand_word(), WEIGHT_W'($urandom()),
                  1'($urandom()));
        continue;
      end
      sent++;
    end
  endtask

  // receiver stalls long enough for the input queue to back up
  task automatic test_full_backpressure();
    hold_cycles = HOLD_OFF;
    for (int n = 0; n < 20; n++) begin
      send_beat(OP_GAIN, any_loaded_item(), '0, '0, '0, 1'($urandom()));
    end
  endtask

  initial begin : result_drain
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : score_checker
    score_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_scores.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected beat: value %0h flag %0b", value, already_selected);
      end else begin
        want = expected_scores.pop_front();
        if (value !== want.value || already_selected !== want.flag) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("mismatch: value exp %0h got %0h, flag exp %0b got %0b",
                     want.value, value, want.flag, already_selected);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    push             = 1'b0;
    operation        = '0;
    item_index       = '0;
    concept_index    = '0;
    cover_mask       = '0;
    weight           = '0;
    check_membership = 1'b0;
    covered_now      = '0;
    last_added       = 0;
    foreach (picked[i]) begin
      picked[i]      = 1'b0;
      mask_loaded[i] = 1'b0;
      mask_mem[i]    = '0;
    end
    foreach (weight_mem[c]) weight_mem[c] = '0;
    send_idle_pct = 16;
    recv_idle_pct = 51;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_table_load();
    test_directed_cases();
    test_random_traffic(150);
    send_idle_pct = 51;
    recv_idle_pct = 16;
    test_random_traffic(150);
    test_full_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(135);

    push <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
